/* rtl/b64d_pkg.sv */
// ----------------------------------------------------------------------------
// b64d_pkg
// Shared types, constants and the alphabet lookup of the Base64 stream decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package b64d_pkg;

  // '=' marks padding
  localparam logic [7:0] PAD_CHAR = 8'h3D;

  // entries in the job queue between front and back
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // stop reasons reported on the status result
  typedef enum logic [1:0] {
    STOP_END       = 2'd0,
    STOP_MALFORMED = 2'd1,
    STOP_CAPACITY  = 2'd2
  } stop_t;

  // one unit of work for the back end: up to three bytes, then an optional status
  typedef struct packed {
    logic [23:0] word;
    logic [1:0]  nbytes;
    logic        status;
    logic [15:0] count;
    stop_t       reason;
  } job_t;

  // one result item as it sits in the output register
  typedef struct packed {
    logic [7:0]  out_byte;
    logic        byte_valid;
    logic        done_res;
    logic [15:0] byte_count;
    logic [1:0]  stop_reason;
    logic        last;
  } res_t;

  // alphabet lookup: bit 6 set when the character is in the alphabet
  function automatic logic [6:0] char_code(input logic [7:0] c);
    logic [6:0] r;
    r = 7'd0;
    if (c >= 8'h41 && c <= 8'h5A) begin
      r = {1'b1, 6'(c - 8'h41)};
    end else if (c >= 8'h61 && c <= 8'h7A) begin
      r = {1'b1, 6'(c - 8'h61 + 8'd26)};
    end else if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, 6'(c - 8'h30 + 8'd52)};
    end else if (c == 8'h2B) begin
      r = {1'b1, 6'd62};
    end else if (c == 8'h2F) begin
      r = {1'b1, 6'd63};
    end
    return r;
  endfunction

endpackage

`default_nettype wire

/* rtl/b64d_front.sv */
// ----------------------------------------------------------------------------
// b64d_front
// Accepts characters, collects groups of four, decides each group's outcome
// and keeps the per-string counters. Emits one job per productive item.
// ----------------------------------------------------------------------------
`default_nettype none

module b64d_front
  import b64d_pkg::*;
#(
  parameter int COUNT_WIDTH = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        accept,
  input  wire logic [7:0]  char_in,
  input  wire logic        end_of_string,
  input  wire logic        cfg_wr_en,
  input  wire logic [15:0] cfg_wr_data,
  output logic             enq,
  output job_t             job
);

  // registers
  logic [15:0]            capacity;
  logic [5:0]             slot_value [4];
  logic [3:0]             slot_is_pad;
  logic [1:0]             slot_pos;
  logic [COUNT_WIDTH-1:0] bytes_left;
  logic [COUNT_WIDTH-1:0] bytes_done;
  logic                   halted;
  stop_t                  halt_reason;

  // combinational
  logic [6:0]             code;
  logic                   is_pad;
  logic                   take;
  logic                   group_done;
  logic [5:0]             g_val [4];
  logic [3:0]             g_pad;
  logic                   bad;
  logic [2:0]             trail;
  logic [1:0]             nbytes;
  logic                   cap_fail;
  logic                   emit_ok;
  logic                   halt_grp;
  stop_t                  reason_grp;
  logic [COUNT_WIDTH-1:0] bytes_done_next;
  logic [COUNT_WIDTH-1:0] bytes_left_next;

  // classify the character
  assign code   = char_code(char_in);
  assign is_pad = (char_in == PAD_CHAR);
  assign take   = accept && !end_of_string && !halted && (code[6] || is_pad);
  assign group_done = accept && !halted && (end_of_string || (take && slot_pos == 2'd3));

  // group as it stands after this item: new slot written or tail padded
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      g_val[i] = slot_value[i];
      g_pad[i] = slot_is_pad[i];
      if (end_of_string) begin
        if (2'(i) >= slot_pos) begin
          g_val[i] = 6'd0;
          g_pad[i] = 1'b1;
        end
      end else if (2'(i) == slot_pos) begin
        g_val[i] = is_pad ? 6'd0 : code[5:0];
        g_pad[i] = is_pad;
      end
    end
  end

  // padding analysis: '=' before an alphabet character is malformed
  assign bad = (g_pad[0] && !(g_pad[1] && g_pad[2] && g_pad[3])) ||
               (g_pad[1] && !(g_pad[2] && g_pad[3])) ||
               (g_pad[2] && !g_pad[3]);

  always_comb begin
    priority if (!g_pad[3]) begin
      trail = 3'd0;
    end else if (!g_pad[2]) begin
      trail = 3'd1;
    end else if (!g_pad[1]) begin
      trail = 3'd2;
    end else if (!g_pad[0]) begin
      trail = 3'd3;
    end else begin
      trail = 3'd4;
    end
  end

  assign nbytes   = (trail >= 3'd3) ? 2'd0 : 2'(3'd3 - trail);
  assign cap_fail = bytes_left < COUNT_WIDTH'(nbytes);
  assign emit_ok  = !bad && !cap_fail;
  assign halt_grp = bad || cap_fail || (nbytes != 2'd3);

  always_comb begin
    priority if (bad) begin
      reason_grp = STOP_MALFORMED;
    end else if (cap_fail) begin
      reason_grp = STOP_CAPACITY;
    end else begin
      reason_grp = STOP_END;
    end
  end

  assign bytes_done_next = (group_done && emit_ok) ?
                           bytes_done + COUNT_WIDTH'(nbytes) : bytes_done;

  // remaining allowance: a capacity write reloads it, so does an end item
  always_comb begin
    priority if (cfg_wr_en) begin
      bytes_left_next = COUNT_WIDTH'(cfg_wr_data);
    end else if (accept && end_of_string) begin
      bytes_left_next = COUNT_WIDTH'(capacity);
    end else if (group_done && emit_ok) begin
      bytes_left_next = bytes_left - COUNT_WIDTH'(nbytes);
    end else begin
      bytes_left_next = bytes_left;
    end
  end

  // job for the back end
  always_comb begin
    job.word   = {g_val[0], g_val[1], g_val[2], g_val[3]};
    job.nbytes = (group_done && emit_ok) ? nbytes : 2'd0;
    job.status = accept && end_of_string;
    job.count  = 16'(bytes_done_next);
    job.reason = halted ? halt_reason : reason_grp;
  end

  assign enq = (group_done && emit_ok && nbytes != 2'd0) || (accept && end_of_string);

  // slot payload
  always_ff @(posedge clk) begin
    if (take) begin
      slot_value[slot_pos]  <= is_pad ? 6'd0 : code[5:0];
      slot_is_pad[slot_pos] <= is_pad;
    end
  end

  // control state and counters
  always_ff @(posedge clk) begin
    if (rst) begin
      capacity    <= 16'hFFFF;
      slot_pos    <= 2'd0;
      bytes_left  <= COUNT_WIDTH'(16'hFFFF);
      bytes_done  <= '0;
      halted      <= 1'b0;
      halt_reason <= STOP_END;
    end else begin
      if (accept && end_of_string) begin
        slot_pos    <= 2'd0;
        bytes_done  <= '0;
        halted      <= 1'b0;
        halt_reason <= STOP_END;
      end else if (take) begin
        slot_pos <= slot_pos + 2'd1;
        if (group_done) begin
          bytes_done <= bytes_done_next;
          if (halt_grp) begin
            halted      <= 1'b1;
            halt_reason <= reason_grp;
          end
        end
      end
      bytes_left <= bytes_left_next;
      // capacity register
      if (cfg_wr_en) begin
        capacity <= cfg_wr_data;
      end
    end
  end

`ifndef SYNTH
  // a halt always lands on a group boundary
  a_halt_aligned: assert property (@(posedge clk) disable iff (rst)
    halted |-> slot_pos == 2'd0)
    else $error("front halted with a partial group");

  // every job carries something to emit
  a_job_nonempty: assert property (@(posedge clk) disable iff (rst)
    enq |-> (job.status || job.nbytes != 2'd0))
    else $error("empty job pushed");

  // end item clears the string state
  a_eos_clear: assert property (@(posedge clk) disable iff (rst)
    (accept && end_of_string && !cfg_wr_en) |=>
      (!halted && slot_pos == 2'd0 && bytes_done == '0))
    else $error("string state not cleared after end item");
`endif

endmodule

`default_nettype wire

/* rtl/b64d_queue.sv */
// ----------------------------------------------------------------------------
// b64d_queue
// Short job queue between front and back; head is visible without a request.
// ----------------------------------------------------------------------------
`default_nettype none

module b64d_queue
  import b64d_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic enq,
  input  wire job_t enq_job,
  input  wire logic deq,
  output logic      q_full,
  output logic      q_valid,
  output job_t      head
);

  job_t              mem [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  assign q_full  = (count == QCNT_W'(QDEPTH));
  assign q_valid = (count != '0);
  assign head    = mem[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (enq) begin
      mem[wr_ptr] <= enq_job;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (enq) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr + QPTR_W'(1);
      end
      if (deq) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr + QPTR_W'(1);
      end
      count <= count + QCNT_W'(enq) - QCNT_W'(deq);
    end
  end

`ifndef SYNTH
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    enq |-> (!q_full || deq))
    else $error("job queue overflow");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    deq |-> q_valid)
    else $error("job queue underflow");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= QCNT_W'(QDEPTH))
    else $error("job queue count out of range");
`endif

endmodule

`default_nettype wire

/* rtl/b64d_back.sv */
// ----------------------------------------------------------------------------
// b64d_back
// Walks each job to its output register, one result per cycle if popped.
// ----------------------------------------------------------------------------
`default_nettype none

module b64d_back
  import b64d_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic q_valid,
  input  wire job_t head,
  output logic      deq,
  input  wire logic pop,
  output logic      empty,
  output res_t      res
);

  logic [1:0] idx;
  logic       out_valid;
  logic [2:0] total;
  logic       last_res;
  logic       advance;
  logic       pop_ok;
  res_t       res_next;

  assign total    = 3'(head.nbytes) + 3'(head.status);
  assign last_res = ({1'b0, idx} == total - 3'd1);
  assign pop_ok   = pop && out_valid;
  assign advance  = q_valid && (!out_valid || pop);
  assign deq      = advance && last_res;
  assign empty    = !out_valid;

  // build the result at idx: bytes first, then the status
  always_comb begin
    res_next = '0;
    if ({1'b0, idx} < 3'(head.nbytes)) begin
      unique case (idx)
        2'd0:    res_next.out_byte = head.word[23:16];
        2'd1:    res_next.out_byte = head.word[15:8];
        default: res_next.out_byte = head.word[7:0];
      endcase
      res_next.byte_valid = 1'b1;
    end else begin
      res_next.done_res    = 1'b1;
      res_next.byte_count  = head.count;
      res_next.stop_reason = head.reason;
    end
    res_next.last = last_res;
  end

  // output payload
  always_ff @(posedge clk) begin
    if (advance) begin
      res <= res_next;
    end
  end

  // output valid and position within the job
  always_ff @(posedge clk) begin
    if (rst) begin
      idx       <= 2'd0;
      out_valid <= 1'b0;
    end else begin
      if (advance) begin
        out_valid <= 1'b1;
        idx       <= last_res ? 2'd0 : idx + 2'd1;
      end else if (pop_ok) begin
        out_valid <= 1'b0;
      end
    end
  end

`ifndef SYNTH
  // mid-job the head must stay present
  a_mid_job: assert property (@(posedge clk) disable iff (rst)
    idx != 2'd0 |-> q_valid)
    else $error("job vanished mid-walk");

  // position never runs past the job
  a_idx_bound: assert property (@(posedge clk) disable iff (rst)
    q_valid |-> ({1'b0, idx} < total))
    else $error("result index past end of job");

  // a job is only retired on its last result
  a_deq_last: assert property (@(posedge clk) disable iff (rst)
    deq |=> (out_valid && res.last))
    else $error("job retired without last result");
`endif

endmodule

`default_nettype wire

/* rtl/base64_stream_decoder.sv */
// ----------------------------------------------------------------------------
// base64_stream_decoder
// Streaming Base64 decoder: one character per request in, one result per
// request out.
// ----------------------------------------------------------------------------
// Takes one character per cycle whenever full is low. The front decodes a
// group in the cycle its fourth character (or the end item) arrives and drops
// a job into a 4-entry queue; the back drains it at one result per cycle while
// its output is free or popped. Sustained input rate is one character per
// cycle as long as results are popped as fast as they are produced; full rises
// only when four jobs wait. Results pass the queue, then the output register.
// capacity is set via cfg_wr_en/cfg_wr_data; the user must write it only while
// the block is idle, which the block itself does not enforce. A write also
// reloads the remaining byte allowance. No clearing pass after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module base64_stream_decoder
  import b64d_pkg::*;
#(
  parameter int COUNT_WIDTH = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // input queue side
  input  wire logic        push,
  output logic             full,
  input  wire logic [7:0]  char_in,
  input  wire logic        end_of_string,
  // configuration
  input  wire logic        cfg_wr_en,
  input  wire logic [15:0] cfg_wr_data,
  // result queue side
  output logic             empty,
  input  wire logic        pop,
  output logic [7:0]       out_byte,
  output logic             byte_valid,
  output logic             done_res,
  output logic [15:0]      byte_count,
  output logic [1:0]       stop_reason,
  output logic             last
);

  logic accept;
  logic enq;
  job_t enq_job;
  logic deq;
  logic q_full;
  logic q_valid;
  job_t head;
  res_t res;

  assign full   = q_full;
  assign accept = push && !q_full;

  // front: classify, collect, decide
  b64d_front #(
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .char_in      (char_in),
    .end_of_string(end_of_string),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .enq          (enq),
    .job          (enq_job)
  );

  // job queue
  b64d_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .enq    (enq),
    .enq_job(enq_job),
    .deq    (deq),
    .q_full (q_full),
    .q_valid(q_valid),
    .head   (head)
  );

  // back: expand jobs into results
  b64d_back u_back (
    .clk    (clk),
    .rst    (rst),
    .q_valid(q_valid),
    .head   (head),
    .deq    (deq),
    .pop    (pop),
    .empty  (empty),
    .res    (res)
  );

  assign out_byte    = res.out_byte;
  assign byte_valid  = res.byte_valid;
  assign done_res    = res.done_res;
  assign byte_count  = res.byte_count;
  assign stop_reason = res.stop_reason;
  assign last        = res.last;

endmodule

`default_nettype wire

/* test/tb_base64_stream_decoder.sv */
// ----------------------------------------------------------------------------
// tb_base64_stream_decoder
// Self-checking bench for the streaming Base64 decoder. A short stimulus
// table covers the alphabet edges, skipped characters, padding, malformed
// padding and the end-of-text flush. Random text follows over a range of
// capacity settings, mostly well-formed strings with noise, plus broken
// groups and junk bytes. A behavioral decoder predicts every result and the
// output side checks each popped request field by field, in order.
// ----------------------------------------------------------------------------
module tb_base64_stream_decoder;
  timeunit 1ns;
  timeprecision 1ps;

  import b64d_pkg::*;

  localparam int SETTLE       = 8;
  localparam int STALL_LIMIT  = 1000;
  localparam int PHASE_ITEMS  = 48;
  localparam int NUM_PHASES   = 8;

  // one row of the directed table; typed rows carry their status by hand
  typedef struct packed {
    logic [7:0]  ch;
    logic        eos;
    logic        typed;
    logic [15:0] cnt;
    stop_t       why;
  } row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        push = 1'b0;
  logic        full;
  logic [7:0]  char_in = 8'd0;
  logic        end_of_string = 1'b0;
  logic        cfg_wr_en = 1'b0;
  logic [15:0] cfg_wr_data = 16'd0;
  logic        empty;
  logic        pop = 1'b0;
  logic [7:0]  out_byte;
  logic        byte_valid;
  logic        done_res;
  logic [15:0] byte_count;
  logic [1:0]  stop_reason;
  logic        last;

  base64_stream_decoder dut (
    .clk           (clk),
    .rst           (rst),
    .push          (push),
    .full          (full),
    .char_in       (char_in),
    .end_of_string (end_of_string),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .empty         (empty),
    .pop           (pop),
    .out_byte      (out_byte),
    .byte_valid    (byte_valid),
    .done_res      (done_res),
    .byte_count    (byte_count),
    .stop_reason   (stop_reason),
    .last          (last)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // decoder state as the bench sees it
  logic [15:0] cap_reg    = 16'hFFFF;
  logic [5:0]  grp_val [4] = '{default: 6'd0};
  bit   [3:0]  grp_pad    = '0;
  int          grp_fill   = 0;
  logic [15:0] allow_left = 16'hFFFF;
  logic [15:0] bytes_out  = 16'd0;
  bit          stopped    = 1'b0;
  stop_t       stop_why   = STOP_END;

  res_t decoded_fifo [$];
  res_t burst [$];
  int   fails = 0;
  int   items_sent = 0;
  bit   idle_on = 1'b1;

  logic [15:0] caps [NUM_PHASES] = '{16'd0, 16'd1, 16'd2, 16'd3, 16'd7, 16'd0,
                                      16'hFFFF, 16'd4};

  row_t script [24] = '{
    '{8'h00, 1'b1, 1'b1, 16'd0, STOP_END},        // end item right after reset
    '{"T", 1'b0, 1'b0, 16'd0, STOP_END},
    '{"W", 1'b0, 1'b0, 16'd0, STOP_END},
    '{"F", 1'b0, 1'b0, 16'd0, STOP_END},
    '{"u", 1'b0, 1'b0, 16'd0, STOP_END},
    '{"/", 1'b0, 1'b0, 16'd0, STOP_END},
    '{"+", 1'b0, 1'b0, 16'd0, STOP_END},
    '{"Z", 1'b0, 1'b0, 16'd0, STOP_END},
    '{"9", 1'b0, 1'b0, 16'd0, STOP_END},
    '{8'hFF, 1'b0, 1'b0, 16'd0, STOP_END},        // skipped
    '{"a", 1'b0, 1'b0, 16'd0, STOP_END},
    '{"0", 1'b0, 1'b0, 16'd0, STOP_END},
    '{"z", 1'b0, 1'b0, 16'd0, STOP_END},
    '{"=", 1'b0, 1'b0, 16'd0, STOP_END},          // one pad: two bytes, halt
    '{"A", 1'b0, 1'b0, 16'd0, STOP_END},          // ignored after halt
    '{8'h00, 1'b1, 1'b1, 16'd8, STOP_END},
    '{"=", 1'b0, 1'b0, 16'd0, STOP_END},          // pad ahead of a letter
    '{"Q", 1'b0, 1'b0, 16'd0, STOP_END},
    '{8'h00, 1'b1, 1'b1, 16'd0, STOP_MALFORMED},
    '{"Q", 1'b0, 1'b0, 16'd0, STOP_END},
    '{"Q", 1'b0, 1'b0, 16'd0, STOP_END},
    '{8'h40, 1'b0, 1'b0, 16'd0, STOP_END},        // '@' just below the alphabet
    '{"Q", 1'b0, 1'b0, 16'd0, STOP_END},
    '{8'h00, 1'b1, 1'b0, 16'd0, STOP_END}         // flush of a partial group
  };

  // alphabet lookup; returns 0 for anything outside it
  function automatic bit sextet(input logic [7:0] c, output logic [5:0] v);
    bit ok;
    ok = 1'b1;
    v = 6'd0;
    if (c >= "A" && c <= "Z") v = 6'(c - "A");
    else if (c >= "a" && c <= "z") v = 6'(c - "a" + 8'd26);
    else if (c >= "0" && c <= "9") v = 6'(c - "0" + 8'd52);
    else if (c == "+") v = 6'd62;
    else if (c == "/") v = 6'd63;
    else ok = 1'b0;
    return ok;
  endfunction

  function automatic logic [7:0] glyph(input logic [5:0] v);
    if (v < 26) return 8'("A" + v);
    if (v < 52) return 8'("a" + v - 26);
    if (v < 62) return 8'("0" + v - 52);
    return (v == 62) ? "+" : "/";
  endfunction

  function automatic logic [7:0] soup_char();
    return ($urandom_range(0, 3) == 0) ? PAD_CHAR : glyph(6'($urandom));
  endfunction

  // a byte the decoder skips: neither alphabet nor pad
  function automatic logic [7:0] skip_char();
    logic [7:0] c;
    logic [5:0] v;
    do c = 8'($urandom); while (sextet(c, v) || c == PAD_CHAR);
    return c;
  endfunction

  function automatic res_t status_of(input logic [15:0] cnt, input stop_t why);
    res_t st;
    st = '0;
    st.done_res = 1'b1;
    st.byte_count = cnt;
    st.stop_reason = why;
    return st;
  endfunction

  // decode the four collected slots; bytes go to burst
  function automatic void close_group();
    int trail;
    int nb;
    bit seen;
    bit bad;
    logic [23:0] word;
    res_t b;
    trail = 0;
    seen = 1'b0;
    bad = 1'b0;
    for (int i = 3; i >= 0; i--) begin
      if (!grp_pad[i]) seen = 1'b1;
      else if (seen) bad = 1'b1;
      else trail++;
    end
    word = {grp_val[0], grp_val[1], grp_val[2], grp_val[3]};
    grp_val = '{default: 6'd0};
    grp_pad = '0;
    grp_fill = 0;
    if (bad) begin
      stopped = 1'b1;
      stop_why = STOP_MALFORMED;
      return;
    end
    nb = (trail >= 3) ? 0 : 3 - trail;
    // capacity check wins over the padding halt
    if (allow_left < nb) begin
      stopped = 1'b1;
      stop_why = STOP_CAPACITY;
      return;
    end
    for (int i = 0; i < nb; i++) begin
      b = '0;
      b.out_byte = word[23 - 8*i -: 8];
      b.byte_valid = 1'b1;
      burst.push_back(b);
    end
    allow_left -= 16'(nb);
    bytes_out += 16'(nb);
    if (nb < 3) begin
      stopped = 1'b1;
      stop_why = STOP_END;
    end
  endfunction

  // work out the results of one accepted request into burst
  function automatic void decode_request(input logic [7:0] c, input logic e);
    logic [5:0] v;
    bit ok;
    burst.delete();
    if (e) begin
      if (!stopped) begin
        while (grp_fill < 4) begin
          grp_val[grp_fill] = 6'd0;
          grp_pad[grp_fill] = 1'b1;
          grp_fill++;
        end
        close_group();
      end
      burst.push_back(status_of(bytes_out, stop_why));
      // end of text: back to a fresh string
      grp_val = '{default: 6'd0};
      grp_pad = '0;
      grp_fill = 0;
      allow_left = cap_reg;
      bytes_out = 16'd0;
      stopped = 1'b0;
      stop_why = STOP_END;
    end else if (!stopped) begin
      ok = sextet(c, v);
      if (ok || c == PAD_CHAR) begin
        grp_val[grp_fill] = v;
        grp_pad[grp_fill] = !ok;
        grp_fill++;
        if (grp_fill == 4) close_group();
      end
    end
    if (burst.size() != 0) burst[burst.size() - 1].last = 1'b1;
  endfunction

  task automatic write_capacity(input logic [15:0] v);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cap_reg = v;
    allow_left = v;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // one input request; returns right after the edge that took it
  task automatic send_item(input logic [7:0] c, input logic e, input bit typed,
                           input logic [15:0] cnt, input stop_t why);
    int gap;
    gap = idle_on ? $urandom_range(0, 6) : 0;
    @(negedge clk);
    repeat (gap) begin
      push <= 1'b0;
      @(negedge clk);
    end
    push <= 1'b1;
    char_in <= c;
    end_of_string <= e;
    @(posedge clk);
    while (full) @(posedge clk);
    decode_request(c, e);
    if (typed) begin
      burst.delete();
      burst.push_back(status_of(cnt, why));
      burst[0].last = 1'b1;
    end
    foreach (burst[k]) decoded_fifo.push_back(burst[k]);
    items_sent++;
  endtask

  // drop push, drain every expected result, then let the pipe settle
  task automatic wait_idle();
    @(negedge clk);
    push <= 1'b0;
    while (decoded_fifo.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic send_random_string();
    logic [7:0] text [$];
    logic [23:0] w;
    int kind;
    int n;
    int take;
    int k;
    bit pad_on;
    bit ends;
    idle_on = ($urandom_range(0, 3) != 0);
    kind = $urandom_range(0, 9);
    ends = 1'b1;
    if (kind <= 5) begin
      // well-formed text; padding sometimes left to the end flush
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 24) : $urandom_range(0, 7);
      pad_on = ($urandom_range(0, 2) != 0);
      for (int i = 0; i < n; i += 3) begin
        w = 24'($urandom);
        take = (n - i > 3) ? 3 : n - i;
        text.push_back(glyph(w[23:18]));
        text.push_back(glyph(w[17:12]));
        if (take >= 2) text.push_back(glyph(w[11:6]));
        else if (pad_on) text.push_back(PAD_CHAR);
        if (take == 3) text.push_back(glyph(w[5:0]));
        else if (pad_on) text.push_back(PAD_CHAR);
      end
      if ($urandom_range(0, 4) == 0) begin
        repeat ($urandom_range(1, 3)) text.push_back(soup_char());
      end
    end else if (kind == 6) begin
      repeat ($urandom_range(0, 10)) text.push_back(soup_char());
    end else if (kind == 7) begin
      // raw bytes, string sometimes left open
      repeat ($urandom_range(0, 8)) text.push_back(8'($urandom));
      ends = 1'($urandom_range(0, 1));
    end else if (kind == 8) begin
      // good group, then a pad ahead of a letter in the next one
      w = 24'($urandom);
      for (int i = 0; i < 4; i++) text.push_back(glyph(w[23 - 6*i -: 6]));
      k = $urandom_range(0, 2);
      for (int i = 0; i < 4; i++) begin
        if (i == k) text.push_back(PAD_CHAR);
        else if (i == 3) text.push_back(glyph(6'($urandom)));
        else text.push_back(soup_char());
      end
    end else begin
      repeat ($urandom_range(0, 3)) text.push_back(soup_char());
    end
    foreach (text[i]) begin
      if ($urandom_range(0, 9) == 0) send_item(skip_char(), 1'b0, 1'b0, 16'd0, STOP_END);
      send_item(text[i], 1'b0, 1'b0, 16'd0, STOP_END);
    end
    if (ends) send_item(8'($urandom), 1'b1, 1'b0, 16'd0, STOP_END);
  endtask

  function automatic void check_field(input string name, input logic [15:0] want,
                                      input logic [15:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
      fails++;
    end
  endfunction

  // result side: random pop stalls, in-order check of every popped request
  initial begin : result_side
    int hold;
    res_t want;
    hold = 0;
    wait (!rst);
    forever begin
      @(negedge clk);
      pop <= (hold == 0);
      @(posedge clk);
      if (pop && !empty) begin
        if (decoded_fifo.size() == 0) begin
          $display("%0t: result with nothing expected, byte %0h valid %0b done %0b",
                   $time, out_byte, byte_valid, done_res);
          fails++;
        end else begin
          want = decoded_fifo.pop_front();
          check_field("out_byte", want.out_byte, out_byte);
          check_field("byte_valid", want.byte_valid, byte_valid);
          check_field("done_res", want.done_res, done_res);
          check_field("byte_count", want.byte_count, byte_count);
          check_field("stop_reason", want.stop_reason, stop_reason);
          check_field("last", want.last, last);
        end
        hold = idle_on ? $urandom_range(0, 6) : 0;
      end else if (hold > 0) begin
        hold--;
      end
    end
  end

  // watchdog: ends the run when no request moves for too long
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if (rst || (push && !full) || (pop && !empty)) quiet = 0;
      else quiet++;
    end
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // main sequence: reset, directed table, random phases per capacity
  initial begin : stimulus
    logic [15:0] cap;
    int goal;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    write_capacity(16'hFFFF);
    foreach (script[i]) begin
      send_item(script[i].ch, script[i].eos, script[i].typed, script[i].cnt,
                script[i].why);
    end
    wait_idle();

    for (int p = 0; p < NUM_PHASES; p++) begin
      cap = (p == 5) ? 16'($urandom) : caps[p];
      write_capacity(cap);
      goal = items_sent + PHASE_ITEMS;
      while (items_sent < goal) send_random_string();
      wait_idle();
    end

    if (fails == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/b64d_pkg.sv
rtl/b64d_front.sv
rtl/b64d_queue.sv
rtl/b64d_back.sv
rtl/base64_stream_decoder.sv
test/tb_base64_stream_decoder.sv
